@@ src/indexed_char_sequence_buffer_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the indexed character sequence buffer
// Shorthand for clocked assertions that are disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef INDEXED_CHAR_SEQUENCE_BUFFER_MACROS_SVH
`define INDEXED_CHAR_SEQUENCE_BUFFER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ICS_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ICS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ICS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/ics_pkg.sv @@
// ----------------------------------------------------------------------------
// ics_pkg
// Types and constants shared by the indexed character sequence buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ics_pkg;

	localparam int CHAR_W       = 8;
	localparam int POS_W        = 7;
	localparam int CNT_W        = 7;
	localparam int CMD_W        = 3;
	localparam int ST_W         = 2;
	localparam int CAPACITY_DEF = 64;

	localparam logic [CMD_W-1:0] CMD_READ    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SORTED  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic [POS_W-1:0]         position;
		logic signed [CHAR_W-1:0] char_in;
	} req_t;

	typedef struct packed {
		logic signed [CHAR_W-1:0] char_out;
		logic [ST_W-1:0]          status;
		logic [CNT_W-1:0]         count;
	} rsp_t;

	// Row-wide control broadcast to every cell during the apply cycle.
	typedef struct packed {
		logic insert;
		logic remove;
		logic write;
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ src/ics_cell.sv @@
// ----------------------------------------------------------------------------
// ics_cell
// One storage cell of the row: holds a character, takes it from a neighbor or the input.
// ----------------------------------------------------------------------------
`default_nettype none

module ics_cell (
	input  wire logic                              clk,
	input  wire ics_pkg::cell_ctl_t                ctl,
	input  wire logic                              f_self,
	input  wire logic                              f_prev,
	input  wire logic signed [ics_pkg::CHAR_W-1:0] char_in,
	input  wire logic signed [ics_pkg::CHAR_W-1:0] left_data,
	input  wire logic signed [ics_pkg::CHAR_W-1:0] right_data,
	output logic signed [ics_pkg::CHAR_W-1:0]      data,
	output logic                                   le
);

	logic signed [ics_pkg::CHAR_W-1:0] data_q;

	// The flag marks cells at or after the addressed index; the first marked
	// cell is the addressed one.
	always_ff @(posedge clk) begin
		if (ctl.insert && f_self) begin
			data_q <= f_prev ? left_data : char_in;
		end else if (ctl.remove && f_self) begin
			data_q <= right_data;
		end else if (ctl.write && f_self && !f_prev) begin
			data_q <= char_in;
		end
	end

	assign data = data_q;
	assign le   = (char_in <= data_q);

endmodule

`default_nettype wire

@@ src/indexed_char_sequence_buffer.sv @@
// ----------------------------------------------------------------------------
// indexed_char_sequence_buffer
// Ordered sequence of signed characters kept in a shifting row of cells.
// ----------------------------------------------------------------------------
// A request is accepted when start is high and busy is low; busy then stays
// high in the evaluate and apply states, and the result is shown for one
// cycle with done in the same cycle that busy falls. A new request may be
// accepted in that same cycle, but not while the last one is still busy.
// In the evaluate state every cell compares the incoming character and, for
// a sorted insert, a prefix tree marks the insertion point. In the apply
// state the row shifts or one cell is written. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_char_sequence_buffer #(
	parameter int CAPACITY = ics_pkg::CAPACITY_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire ics_pkg::req_t req,
	output logic               busy,
	output logic               done,
	output ics_pkg::rsp_t      rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CW > ics_pkg::POS_W) ? CW : ics_pkg::POS_W;
	localparam int LV = $clog2(CAPACITY);

	typedef enum logic [1:0] {S_IDLE, S_EVAL, S_APPLY} state_t;

	state_t                             state_q;
	ics_pkg::req_t                      req_q;
	logic [CW-1:0]                      count_q;
	logic [CAPACITY-1:0]                flags_q;
	logic                               done_q;
	ics_pkg::rsp_t                      rsp_q;

	logic signed [ics_pkg::CHAR_W-1:0]  cell_data [CAPACITY];
	logic [CAPACITY-1:0]                le_vec;
	logic [CAPACITY-1:0]                geq_pos;
	logic [CAPACITY-1:0]                beyond;
	logic [CAPACITY-1:0]                pre [LV+1];
	logic [CAPACITY-1:0]                flags_next;
	logic [CAPACITY-1:0]                sel;

	logic [IW-1:0]                      pos_ext;
	logic [IW-1:0]                      count_ext;
	logic                               full;
	logic                               in_range;
	logic [ics_pkg::ST_W-1:0]           status;
	logic                               ok;
	ics_pkg::cell_ctl_t                 ctl;
	logic signed [ics_pkg::CHAR_W-1:0]  rd_data;
	logic [CW-1:0]                      count_next;

	assign pos_ext   = IW'(req_q.position);
	assign count_ext = IW'(count_q);
	assign full      = (count_q == CW'(CAPACITY));

	genvar gi, gl;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_row
			localparam logic [IW-1:0] IDX = IW'(gi);
			logic signed [ics_pkg::CHAR_W-1:0] left_d;
			logic signed [ics_pkg::CHAR_W-1:0] right_d;
			logic                              f_prev;

			if (gi == 0) begin : g_first
				assign left_d = req_q.char_in;
				assign f_prev = 1'b0;
			end else begin : g_mid
				assign left_d = cell_data[gi-1];
				assign f_prev = flags_q[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign right_d = cell_data[gi];
			end else begin : g_inner
				assign right_d = cell_data[gi+1];
			end

			ics_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.f_self     (flags_q[gi]),
				.f_prev     (f_prev),
				.char_in    (req_q.char_in),
				.left_data  (left_d),
				.right_data (right_d),
				.data       (cell_data[gi]),
				.le         (le_vec[gi])
			);

			assign geq_pos[gi] = (IDX >= pos_ext);
			assign beyond[gi]  = (count_ext <= IDX);
			assign sel[gi]     = flags_q[gi] & ~f_prev;
		end

		// Parallel prefix OR: a cell is marked once any valid cell at or
		// before it holds a value not less than the new character.
		assign pre[0] = le_vec & ~beyond;
		for (gl = 0; gl < LV; gl++) begin : g_lvl
			for (gi = 0; gi < CAPACITY; gi++) begin : g_bit
				if (gi >= (1 << gl)) begin : g_or
					assign pre[gl+1][gi] = pre[gl][gi] | pre[gl][gi-(1<<gl)];
				end else begin : g_pass
					assign pre[gl+1][gi] = pre[gl][gi];
				end
			end
		end
	endgenerate

	assign flags_next = (req_q.cmd == ics_pkg::CMD_SORTED) ? (pre[LV] | beyond) : geq_pos;

	always_comb begin
		in_range = 1'b1;
		status   = ics_pkg::ST_OK;
		case (req_q.cmd)
			ics_pkg::CMD_READ, ics_pkg::CMD_REMOVE, ics_pkg::CMD_REPLACE: begin
				in_range = (pos_ext < count_ext);
				status   = in_range ? ics_pkg::ST_OK : ics_pkg::ST_RANGE;
			end
			ics_pkg::CMD_INSERT: begin
				in_range = (pos_ext <= count_ext);
				if (!in_range) begin
					status = ics_pkg::ST_RANGE;
				end else if (full) begin
					status = ics_pkg::ST_FULL;
				end
			end
			ics_pkg::CMD_SORTED: begin
				status = full ? ics_pkg::ST_FULL : ics_pkg::ST_OK;
			end
			default: begin
				status = ics_pkg::ST_OK;
			end
		endcase
		ok = (status == ics_pkg::ST_OK);
	end

	always_comb begin
		ctl.insert = 1'b0;
		ctl.remove = 1'b0;
		ctl.write  = 1'b0;
		if (state_q == S_APPLY && ok) begin
			ctl.insert = (req_q.cmd == ics_pkg::CMD_INSERT) ||
			             (req_q.cmd == ics_pkg::CMD_SORTED);
			ctl.remove = (req_q.cmd == ics_pkg::CMD_REMOVE);
			ctl.write  = (req_q.cmd == ics_pkg::CMD_REPLACE);
		end
	end

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_data = rd_data | (cell_data[i] & {ics_pkg::CHAR_W{sel[i]}});
		end
		if (!(ok && req_q.cmd == ics_pkg::CMD_READ)) begin
			rd_data = '0;
		end
	end

	always_comb begin
		count_next = count_q;
		if (ok) begin
			if (req_q.cmd == ics_pkg::CMD_INSERT || req_q.cmd == ics_pkg::CMD_SORTED) begin
				count_next = count_q + CW'(1);
			end else if (req_q.cmd == ics_pkg::CMD_REMOVE) begin
				count_next = count_q - CW'(1);
			end else if (req_q.cmd == ics_pkg::CMD_CLEAR) begin
				count_next = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q   <= '0;
			flags_q <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q   <= req;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					flags_q <= flags_next;
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					count_q        <= count_next;
					rsp_q.char_out <= rd_data;
					rsp_q.status   <= status;
					rsp_q.count    <= ics_pkg::CNT_W'(count_next);
					done_q         <= 1'b1;
					state_q        <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

@@ src/ics_checker.sv @@
// ----------------------------------------------------------------------------
// ics_checker
// Port-level checks on request timing and result fields of the buffer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_char_sequence_buffer_macros.svh"

module ics_checker #(
	parameter int CAPACITY = ics_pkg::CAPACITY_DEF
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire ics_pkg::req_t req,
	input wire logic          busy,
	input wire logic          done,
	input wire ics_pkg::rsp_t rsp
);

	logic accepted;
	assign accepted = start && !busy;

	// An accepted request is answered with done after the evaluate and apply states.
	`ICS_ASSERT_IMP(a_latency, accepted, ##3 done, "result strobe missing after request")

	`ICS_ASSERT_NXT(a_busy_after_accept, accepted, busy && !done, "busy not raised after request")

	`ICS_ASSERT_IMP(a_done_idle, done, !busy, "result shown while still busy")

	`ICS_ASSERT_IMP(a_status_code, done,
		rsp.status == ics_pkg::ST_OK || rsp.status == ics_pkg::ST_RANGE ||
		rsp.status == ics_pkg::ST_FULL, "undefined status code")

	// Only a successful read returns a character.
	`ICS_ASSERT_IMP(a_char_ok, done && rsp.char_out != 0, rsp.status == ics_pkg::ST_OK,
		"character returned with error status")

	logic unused_req;
	assign unused_req = ^req;

endmodule

bind indexed_char_sequence_buffer ics_checker #(.CAPACITY(CAPACITY)) u_ics_checker (.*);

`default_nettype wire
